@@ design/assert_macros.svh @@
// assertion macros for the checker file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked assertion that also holds while reset is asserted
`define ASSERT_CLK_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ design/isr_pkg.sv @@
// shared constants for the integer square root pipeline
// no dependencies
package isr_pkg;

    localparam int DEF_IN_WIDTH = 32;
    localparam int ROOT_W       = 16;

endpackage

@@ design/isr_radicand_if.sv @@
// valid/ready channel carrying one radicand per beat
// depends on isr_pkg
interface isr_radicand_if
    import isr_pkg::*;
#(
    parameter int W = DEF_IN_WIDTH
);
    logic         valid;
    logic         ready;
    logic [W-1:0] radicand;

    modport source (output valid, output radicand, input ready);
    modport sink   (input valid, input radicand, output ready);
endinterface

@@ design/isr_root_if.sv @@
// valid/ready channel carrying one root per beat
// depends on isr_pkg
interface isr_root_if
    import isr_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [ROOT_W-1:0] root;

    modport source (output valid, output root, input ready);
    modport sink   (input valid, input root, output ready);
endinterface

@@ design/isr_stage.sv @@
// one digit-by-digit iteration: trial subtract of one bit-pair weight, registered
// standalone, instantiated by integer_square_root
module isr_stage #(
    parameter int W     = 32,
    parameter int SHIFT = 0
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         up_valid,
    output logic         up_ready,
    input  logic [W-1:0] up_rem,
    input  logic [W-1:0] up_part,
    output logic         dn_valid,
    input  logic         dn_ready,
    output logic [W-1:0] dn_rem,
    output logic [W-1:0] dn_part
);

    localparam logic [W-1:0] WEIGHT = W'(1) << SHIFT;

    logic         valid_reg;
    logic [W-1:0] rem_reg;
    logic [W-1:0] part_reg;
    logic [W-1:0] rem_next;
    logic [W-1:0] part_next;
    logic [W:0]   trial;
    logic         load;

    assign up_ready = !valid_reg || dn_ready;
    assign load     = up_valid && up_ready;

    always_comb
    begin
        trial     = {1'b0, up_part} + {1'b0, WEIGHT};
        rem_next  = up_rem;
        part_next = up_part >> 1;
        if ({1'b0, up_rem} >= trial)
        begin
            rem_next  = up_rem - trial[W-1:0];
            part_next = (up_part >> 1) + WEIGHT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rem_reg  <= rem_next;
            part_reg <= part_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_rem   = rem_reg;
    assign dn_part  = part_reg;

endmodule

@@ design/integer_square_root.sv @@
// integer square root top level: a chain of registered iteration stages
// depends on isr_pkg, isr_radicand_if, isr_root_if, isr_stage
//
//  channel       | modport | payload
//  --------------+---------+--------------------------------
//  radicand_ch   | sink    | radicand [IN_WIDTH-1:0] unsigned
//  root_ch       | source  | root [15:0] unsigned
//
// one stage per result bit: (IN_WIDTH-1)/2+1 stages, 16 for a 32-bit radicand
// a new beat can enter every cycle unless a stall backs up to the first stage
// each stage holds one trial subtract and compare of IN_WIDTH+1 bits
// the last stage register drives root_ch directly
// reset clears stage valid bits only; stalls hold full stages up to a bubble
module integer_square_root
    import isr_pkg::*;
#(
    parameter int IN_WIDTH = DEF_IN_WIDTH
) (
    input logic                 clk,
    input logic                 rst_n,
    isr_radicand_if.sink        radicand_ch,
    isr_root_if.source          root_ch
);

    localparam int ITERS = (IN_WIDTH - 1) / 2 + 1;

    logic                valid_ch [ITERS+1];
    logic                ready_ch [ITERS+1];
    logic [IN_WIDTH-1:0] rem_ch   [ITERS+1];
    logic [IN_WIDTH-1:0] part_ch  [ITERS+1];

    assign valid_ch[0]       = radicand_ch.valid;
    assign rem_ch[0]         = radicand_ch.radicand;
    assign part_ch[0]        = '0;
    assign radicand_ch.ready = ready_ch[0];

    // weight falls by a factor of four per stage, starting at the top even bit
    for (genvar k = 0; k < ITERS; k++)
    begin : g_stage
        isr_stage #(
            .W     (IN_WIDTH),
            .SHIFT (2 * (ITERS - 1 - k))
        ) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (valid_ch[k]),
            .up_ready (ready_ch[k]),
            .up_rem   (rem_ch[k]),
            .up_part  (part_ch[k]),
            .dn_valid (valid_ch[k+1]),
            .dn_ready (ready_ch[k+1]),
            .dn_rem   (rem_ch[k+1]),
            .dn_part  (part_ch[k+1])
        );
    end

    assign root_ch.valid   = valid_ch[ITERS];
    assign root_ch.root    = ROOT_W'(part_ch[ITERS]);
    assign ready_ch[ITERS] = root_ch.ready;

endmodule

@@ design/isr_checker.sv @@
// port-level checks for integer_square_root, attached by bind
// depends on isr_pkg and assert_macros.svh
`include "assert_macros.svh"

module isr_checker
    import isr_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [ROOT_W-1:0] out_root
);

    // no result beat can be offered while reset holds
    `ASSERT_CLK_NR(a_no_valid_in_reset, clk, !rst_n |-> !out_valid, "root valid during reset")

    // a stalled result keeps being offered
    `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "root beat dropped")

    // a stalled result keeps its value
    `ASSERT_CLK(a_out_stable, clk, rst_n, out_valid && !out_ready |=> $stable(out_root), "root moved")

    // a drained or moving output frees the whole chain for a new beat
    `ASSERT_CLK(a_in_ready, clk, rst_n, (!out_valid || out_ready) |-> in_ready, "input blocked")

    // no input beat may be taken while reset holds
    `ASSERT_CLK_NR(a_no_accept_in_reset, clk, !rst_n |-> !(in_valid && in_ready), "accept in reset")

endmodule

bind integer_square_root isr_checker u_isr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (radicand_ch.valid),
    .in_ready  (radicand_ch.ready),
    .out_valid (root_ch.valid),
    .out_ready (root_ch.ready),
    .out_root  (root_ch.root)
);

@@ tb/sv/tb.sv @@
// self-checking bench for integer_square_root: random and corner radicands, checked roots
// depends on isr_pkg, isr_radicand_if, isr_root_if and the integer_square_root rtl
module tb;
    import isr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  W           = DEF_IN_WIDTH;
    localparam int  STAGES      = (W - 1) / 2 + 1;
    localparam int  RAND_ITEMS  = 402;
    localparam int  HOLD_CYCLES = 80;
    localparam int  CYCLE_LIMIT = 200000;
    localparam int  REPORT_MAX  = 10;

    // floor root prediction and the store of roots still owed by the block
    class root_scoreboard;
        logic [ROOT_W-1:0] roots_owed[$];
        int                bad_roots;
        int                stray_roots;

        function automatic logic [ROOT_W-1:0] floor_sqrt(logic [W-1:0] n);
            logic [W:0] weight;
            logic [W:0] part;
            logic [W:0] rest;
            logic [W:0] trial;
            int         i;
            weight = {{W{1'b0}}, 1'b1} << ((W - 1) & ~1);
            part   = '0;
            rest   = {1'b0, n};
            for (i = 0; i < STAGES; i++)
            begin
                trial = part + weight;
                part  = part >> 1;
                if (rest >= trial)
                begin
                    rest = rest - trial;
                    part = part + weight;
                end
                weight = weight >> 2;
            end
            return part[ROOT_W-1:0];
        endfunction

        function void note_radicand(logic [W-1:0] n);
            roots_owed.push_back(floor_sqrt(n));
        endfunction

        function void check_root(logic [ROOT_W-1:0] got);
            logic [ROOT_W-1:0] want;
            if (roots_owed.size() == 0)
            begin
                stray_roots++;
                if (bad_roots + stray_roots <= REPORT_MAX)
                    $display("root beat %0h arrived with no radicand pending", got);
                return;
            end
            want = roots_owed.pop_front();
            if (got !== want)
            begin
                bad_roots++;
                if (bad_roots + stray_roots <= REPORT_MAX)
                    $display("root differs: expected %0h, got %0h", want, got);
            end
        endfunction

        function int failures();
            return bad_roots + stray_roots + roots_owed.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    isr_radicand_if #(.W(W)) rad_if ();
    isr_root_if              root_if ();

    integer_square_root #(.IN_WIDTH(W)) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .radicand_ch (rad_if),
        .root_ch     (root_if)
    );

    root_scoreboard sb = new();

    int tx_idle_pct;
    int rx_idle_pct;
    int phase;
    bit pressure_done;
    int hold_left;
    int cycles;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // monitors see pre-edge values, the same ones the block samples
    always @(posedge clk)
    begin
        if (rst_n && rad_if.valid && rad_if.ready)
            sb.note_radicand(rad_if.radicand);
        if (rst_n && root_if.valid && root_if.ready)
            sb.check_root(root_if.root);
    end

    // receiver: random stalls, plus one long hold-off so the pipeline fills
    initial
    begin
        root_if.ready <= 1'b0;
        hold_left     = 0;
        pressure_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (phase == 3 && !pressure_done)
            begin
                pressure_done = 1'b1;
                hold_left     = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                root_if.ready <= 1'b0;
            end
            else
                root_if.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic send_radicand(logic [W-1:0] n);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            rad_if.valid <= 1'b0;
            @(posedge clk);
        end
        rad_if.valid    <= 1'b1;
        rad_if.radicand <= n;
        @(posedge clk);
        while (!(rad_if.valid && rad_if.ready))
            @(posedge clk);
    endtask

    function automatic logic [W-1:0] random_radicand();
        logic [W-1:0]      n;
        logic [ROOT_W-1:0] r;
        r = ROOT_W'($urandom_range(0, (1 << ROOT_W) - 1));
        case ($urandom_range(5))
            0: n = $urandom;
            1: n = W'(r) * W'(r);
            2: n = W'(r) * W'(r) - W'(r != 0);
            3: n = W'(r) * W'(r) + 2 * W'(r);
            4: n = $urandom_range(0, 1023);
            default: n = $urandom >> $urandom_range(W - 1);
        endcase
        return n;
    endfunction

    logic [W-1:0] corner_radicands[] = '{
        32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003,
        32'h0000_0004, 32'h0000_0008, 32'h0000_0010, 32'h0000_00FF,
        32'h0001_0000, 32'h0000_FFFF, 32'h3FFF_FFFF, 32'h4000_0000,
        32'h4000_0001, 32'h7FFF_FFFF, 32'h8000_0000, 32'hC000_0000,
        32'hFFFE_0000, 32'hFFFE_0001, 32'hFFFE_0002, 32'hFFFF_FFFE,
        32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555
    };

    initial
    begin
        int i;
        int p;
        int drain;
        rst_n           <= 1'b0;
        rad_if.valid    <= 1'b0;
        rad_if.radicand <= '0;
        phase       = 0;
        tx_idle_pct = 36;
        rx_idle_pct = 88;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        phase = 1;
        foreach (corner_radicands[k])
            send_radicand(corner_radicands[k]);

        for (p = 1; p <= 3; p++)
        begin
            phase = p;
            case (p)
                1: begin tx_idle_pct = 36; rx_idle_pct = 88; end
                2: begin tx_idle_pct = 88; rx_idle_pct = 36; end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            for (i = 0; i < RAND_ITEMS / 3; i++)
                send_radicand(random_radicand());
        end
        rad_if.valid <= 1'b0;

        while (sb.roots_owed.size() != 0)
            @(posedge clk);
        // allow for any beat still in flight past the last expected root
        for (drain = 0; drain < 2 * STAGES; drain++)
            @(posedge clk);

        if (sb.failures() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

@@ integer_square_root.f @@
+incdir+design
design/isr_pkg.sv
design/isr_radicand_if.sv
design/isr_root_if.sv
design/isr_stage.sv
design/integer_square_root.sv
design/isr_checker.sv
tb/sv/tb.sv
